[rtl/sle_pkg.sv]
// shared types, codes and constants for the serial line editor
`default_nettype none

package sle_pkg;

  // default line store depth
  localparam int unsigned LineCapacityDef = 16;

  // command queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // operation codes of an input transaction
  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_SERVICE = 1'b1;

  // result kinds
  localparam logic [2:0] KIND_ECHO = 3'd0;
  localparam logic [2:0] KIND_LINE = 3'd1;
  localparam logic [2:0] KIND_END  = 3'd2;
  localparam logic [2:0] KIND_OVF  = 3'd3;
  localparam logic [2:0] KIND_TAB  = 3'd4;

  // byte values that matter
  localparam logic [6:0] CHAR_BS      = 7'd8;
  localparam logic [6:0] CHAR_TAB     = 7'd9;
  localparam logic [6:0] CHAR_CR      = 7'd13;
  localparam logic [6:0] CHAR_ESC     = 7'd27;
  localparam logic [6:0] CHAR_SPACE   = 7'd32;
  localparam logic [6:0] CHAR_BRACKET = 7'd91;
  localparam logic [6:0] CHAR_UP      = 7'd65;
  localparam logic [6:0] CHAR_DOWN    = 7'd66;
  localparam logic [6:0] CHAR_RIGHT   = 7'd67;
  localparam logic [6:0] CHAR_LEFT    = 7'd68;

  // pending event codes
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_BACKSPACE = 3'd1,
    EV_TAB       = 3'd2,
    EV_ENTER     = 3'd3,
    EV_UP        = 3'd4,
    EV_DOWN      = 3'd5,
    EV_OVERFLOW  = 3'd6
  } event_e;

  // byte class worked out by the front end
  typedef enum logic [2:0] {
    CLS_SERVICE = 3'd0,
    CLS_PRINT   = 3'd1,
    CLS_ESC     = 3'd2,
    CLS_BS      = 3'd3,
    CLS_TAB     = 3'd4,
    CLS_CR      = 3'd5,
    CLS_CTRL    = 3'd6
  } class_e;

  // back end sequencer states
  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_BS   = 3'd1,
    S_UP   = 3'd2,
    S_ECHO = 3'd3,
    S_LINE = 3'd4,
    S_END  = 3'd5
  } state_e;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [6:0] character;
    logic [4:0] line_length;
    logic       last;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    class_e     cls;
    logic [6:0] character;
  } cmd_t;

endpackage

`default_nettype wire

[rtl/sle_front.sv]
// front end: accepts input transactions, drops high bytes and classifies the rest
`default_nettype none

module sle_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire sle_pkg::in_item_t in_data_i,
  output logic                  push_o,
  output sle_pkg::cmd_t         push_cmd_o,
  input  wire logic             queue_full_i
);
  import sle_pkg::*;

  logic accept;
  logic unused_clk;

  // the front end is purely combinational
  assign unused_clk = clk_i ^ rst_ni;

  // stall while the queue has no room
  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;

  // classify the byte
  always_comb begin
    push_cmd_o.character = in_data_i.rx_byte[6:0];
    push_o               = 1'b0;
    if (in_data_i.operation == OP_SERVICE) begin
      push_cmd_o.cls = CLS_SERVICE;
    end else if (in_data_i.rx_byte[6:5] != 2'b00) begin
      push_cmd_o.cls = CLS_PRINT;
    end else begin
      case (in_data_i.rx_byte[6:0])
        CHAR_ESC: push_cmd_o.cls = CLS_ESC;
        CHAR_BS:  push_cmd_o.cls = CLS_BS;
        CHAR_TAB: push_cmd_o.cls = CLS_TAB;
        CHAR_CR:  push_cmd_o.cls = CLS_CR;
        default:  push_cmd_o.cls = CLS_CTRL;
      endcase
    end
    // received bytes above 127 are always dropped, so they never reach the queue
    if (accept && !(in_data_i.operation == OP_RECEIVE && in_data_i.rx_byte[7])) begin
      push_o = 1'b1;
    end
  end

endmodule

`default_nettype wire

[rtl/sle_queue.sv]
// short command queue between the front and back ends
`default_nettype none

module sle_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sle_pkg::cmd_t  push_cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output sle_pkg::cmd_t       head_o
);
  import sle_pkg::*;

  cmd_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == QueueCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QueuePtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QueuePtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QueueCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QueueCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // payload slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

[rtl/sle_back.sv]
// back end: editor state, line store and the result sequencer
`default_nettype none

module sle_back #(
  parameter int unsigned LINE_CAPACITY = sle_pkg::LineCapacityDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cmd_valid_i,
  input  wire sle_pkg::cmd_t    cmd_i,
  output logic                  cmd_pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output sle_pkg::out_item_t    out_data_o
);
  import sle_pkg::*;

  localparam int unsigned IdxW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

  state_e     state_q, state_d;
  logic       pend_q, pend_d;
  event_e     code_q, code_d;
  logic [1:0] esc_q, esc_d;
  logic [4:0] len_q, len_d;
  logic [4:0] prev_q, prev_d;
  logic [4:0] shown_q, shown_d;
  logic [4:0] idx_q, idx_d;
  logic       up_mode_q, up_mode_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  logic [6:0] store_q [LINE_CAPACITY];
  logic       wr_en;
  logic [6:0] wr_char;
  logic [4:0] rd_sel;
  logic [6:0] rd_char;
  logic       can_emit;
  logic       emit;
  out_item_t  res;
  logic [4:0] new_prev;
  logic       normal;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign can_emit    = !out_valid_q || !out_stall_i;

  // single read port of the line store
  always_comb begin
    case (state_q)
      S_ECHO, S_LINE: rd_sel = idx_q;
      S_UP:           rd_sel = prev_q - 5'd1;
      default:        rd_sel = shown_q;
    endcase
  end
  assign rd_char = store_q[rd_sel[IdxW-1:0]];

  // next state, editor state and results
  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    code_d      = code_q;
    esc_d       = esc_q;
    len_d       = len_q;
    prev_d      = prev_q;
    shown_d     = shown_q;
    idx_d       = idx_q;
    up_mode_d   = up_mode_q;
    cmd_pop_o   = 1'b0;
    emit        = 1'b0;
    res         = '0;
    wr_en       = 1'b0;
    wr_char     = cmd_i.character;
    new_prev    = prev_q;
    normal      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && can_emit) begin
          cmd_pop_o = 1'b1;
          if (cmd_i.cls == CLS_SERVICE) begin
            if (!pend_q) begin
              // echo one unshown character
              if (shown_q < len_q) begin
                emit          = 1'b1;
                res.kind      = KIND_ECHO;
                res.character = rd_char;
                res.last      = 1'b1;
                shown_d       = shown_q + 5'd1;
              end
            end else begin
              pend_d = 1'b0;
              case (code_q)
                EV_BACKSPACE: begin
                  len_d   = (len_q != '0) ? len_q - 5'd1 : len_q;
                  shown_d = (len_q != '0) ? len_q - 5'd1 : len_q;
                  idx_d   = '0;
                  state_d = S_BS;
                end
                EV_TAB: begin
                  emit     = 1'b1;
                  res.kind = KIND_TAB;
                  res.last = 1'b1;
                end
                EV_ENTER: begin
                  idx_d   = '0;
                  state_d = (len_q == '0) ? S_END : S_LINE;
                end
                EV_UP: begin
                  if (len_q == '0) begin
                    state_d = S_UP;
                  end
                end
                EV_DOWN: begin
                  if (len_q == '0) begin
                    len_d     = prev_q;
                    shown_d   = prev_q;
                    idx_d     = '0;
                    up_mode_d = 1'b0;
                    state_d   = (prev_q == '0) ? S_END : S_ECHO;
                  end
                end
                EV_OVERFLOW: begin
                  emit     = 1'b1;
                  res.kind = KIND_OVF;
                  res.last = 1'b1;
                  prev_d   = len_q;
                  len_d    = '0;
                end
                default: begin
                end
              endcase
            end
          end else if (!pend_q) begin
            // escape prefix tracking
            if (esc_q == 2'd1) begin
              if (cmd_i.character == CHAR_BRACKET) begin
                esc_d = 2'd2;
              end else begin
                esc_d  = '0;
                normal = 1'b1;
              end
            end else if (esc_q == 2'd2) begin
              esc_d = '0;
              case (cmd_i.character)
                CHAR_UP: begin
                  pend_d = 1'b1;
                  code_d = EV_UP;
                end
                CHAR_DOWN: begin
                  pend_d = 1'b1;
                  code_d = EV_DOWN;
                end
                CHAR_RIGHT, CHAR_LEFT: begin
                  pend_d = 1'b1;
                  code_d = EV_NONE;
                end
                default: begin
                end
              endcase
            end else begin
              normal = 1'b1;
            end
            // ordinary byte
            if (normal) begin
              case (cmd_i.cls)
                CLS_ESC: esc_d = 2'd1;
                CLS_BS: begin
                  pend_d = 1'b1;
                  code_d = EV_BACKSPACE;
                end
                CLS_TAB: begin
                  pend_d = 1'b1;
                  code_d = EV_TAB;
                end
                CLS_CR: begin
                  pend_d = 1'b1;
                  code_d = EV_ENTER;
                end
                CLS_PRINT: begin
                  if (len_q >= 5'(LINE_CAPACITY)) begin
                    pend_d = 1'b1;
                    code_d = EV_OVERFLOW;
                  end else begin
                    wr_en = 1'b1;
                    len_d = len_q + 5'd1;
                  end
                end
                default: begin
                  pend_d = 1'b1;
                  code_d = EV_NONE;
                end
              endcase
            end
          end
        end
      end
      S_BS: begin
        // backspace, space, backspace
        if (can_emit) begin
          emit          = 1'b1;
          res.kind      = KIND_ECHO;
          res.character = (idx_q == 5'd1) ? CHAR_SPACE : CHAR_BS;
          res.last      = (idx_q == 5'd2);
          idx_d         = idx_q + 5'd1;
          if (idx_q == 5'd2) begin
            state_d = S_IDLE;
          end
        end
      end
      S_UP: begin
        // trim a trailing space from the history line, then recall it
        if (prev_q != '0 && rd_char == CHAR_SPACE) begin
          new_prev = prev_q - 5'd1;
        end
        prev_d    = new_prev;
        len_d     = new_prev;
        shown_d   = new_prev;
        idx_d     = '0;
        up_mode_d = 1'b1;
        state_d   = (new_prev == '0) ? S_IDLE : S_ECHO;
      end
      S_ECHO: begin
        if (can_emit) begin
          emit          = 1'b1;
          res.kind      = KIND_ECHO;
          res.character = rd_char;
          res.last      = up_mode_q && (idx_q == len_q - 5'd1);
          idx_d         = idx_q + 5'd1;
          if (idx_q == len_q - 5'd1) begin
            if (up_mode_q) begin
              state_d = S_IDLE;
            end else begin
              idx_d   = '0;
              state_d = S_LINE;
            end
          end
        end
      end
      S_LINE: begin
        if (can_emit) begin
          emit          = 1'b1;
          res.kind      = KIND_LINE;
          res.character = rd_char;
          idx_d         = idx_q + 5'd1;
          if (idx_q == len_q - 5'd1) begin
            state_d = S_END;
          end
        end
      end
      S_END: begin
        if (can_emit) begin
          emit            = 1'b1;
          res.kind        = KIND_END;
          res.line_length = len_q;
          res.last        = 1'b1;
          if (len_q != '0) begin
            prev_d = len_q;
          end
          len_d   = '0;
          shown_d = '0;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= 1'b0;
      code_q      <= EV_NONE;
      esc_q       <= '0;
      len_q       <= '0;
      prev_q      <= '0;
      shown_q     <= '0;
      idx_q       <= '0;
      up_mode_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      code_q      <= code_d;
      esc_q       <= esc_d;
      len_q       <= len_d;
      prev_q      <= prev_d;
      shown_q     <= shown_d;
      idx_q       <= idx_d;
      up_mode_q   <= up_mode_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (wr_en) begin
      store_q[len_q[IdxW-1:0]] <= wr_char;
    end
  end

endmodule

`default_nettype wire

[rtl/serial_line_editor.sv]
// Serial line editor: byte receiver with arrow-key escapes, line store and history.
// Receive, echo, tab and overflow transactions register their result at the edge that
// takes the command. Backspace, enter and down give their first result from the state
// they pass to (S_BS, S_LINE, S_ECHO or S_END), recall via S_UP; then one result a cycle
// while the output is not stalled. A two-entry queue decouples input from the back end.
// Reset clears all control state; the line store is left unset until written.
`default_nettype none

module serial_line_editor #(
  parameter int unsigned LINE_CAPACITY = sle_pkg::LineCapacityDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire sle_pkg::in_item_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output sle_pkg::out_item_t      out_data_o
);
  import sle_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic queue_full;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // classification of incoming transactions
  sle_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .queue_full_i (queue_full)
  );

  // command queue
  sle_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (queue_full),
    .pop_i      (cmd_pop),
    .valid_o    (cmd_valid),
    .head_o     (cmd)
  );

  // editor state and result sequencing
  sle_back #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[bench/serial_line_editor_tb.sv]
// self-checking testbench for the serial line editor: directed and random transactions
`default_nettype none

module serial_line_editor_tb;
  import sle_pkg::*;

  localparam int unsigned LINE_CAP     = LineCapacityDef;
  localparam int unsigned RANDOM_ITEMS = 360;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 2 * LINE_CAP + 16;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned REPORT_CAP   = 20;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  serial_line_editor #(
    .LINE_CAPACITY(LINE_CAP)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // editor state as the predictor sees it
  logic       evt_pending;
  event_e     evt_code;
  logic [1:0] esc_step;
  logic [4:0] cur_len;
  logic [4:0] hist_len;
  logic [4:0] echoed_len;
  logic [6:0] line_buf [LINE_CAP];

  // output transactions the editor still owes, oldest first
  out_item_t editor_output_q[$];

  int unsigned items_sent;
  int unsigned items_acted;
  int unsigned results_checked;
  int unsigned overflow_seen;
  int unsigned lines_seen;
  int unsigned tabs_seen;
  int unsigned mismatch_count;
  int unsigned idle_cycles = 0;
  bit          no_idle;
  bit          hold_output_req;

  function automatic void reset_editor_model();
    evt_pending = 1'b0;
    evt_code    = EV_NONE;
    esc_step    = 2'd0;
    cur_len     = 5'd0;
    hist_len    = 5'd0;
    echoed_len  = 5'd0;
    for (int i = 0; i < LINE_CAP; i++) line_buf[i] = 7'd0;
  endfunction

  function automatic void add_result(logic [2:0] kind, logic [6:0] ch, logic [4:0] len);
    out_item_t r;
    r.kind        = kind;
    r.character   = ch;
    r.line_length = len;
    r.last        = 1'b0;
    editor_output_q.push_back(r);
  endfunction

  function automatic void post_event(event_e code);
    evt_pending = 1'b1;
    evt_code    = code;
  endfunction

  // echo the whole current line
  function automatic void echo_whole_line();
    for (int i = 0; i < cur_len; i++) add_result(KIND_ECHO, line_buf[i], 5'd0);
    echoed_len = cur_len;
  endfunction

  // hand the line over, then the end marker with its length
  function automatic void close_line();
    for (int i = 0; i < cur_len; i++) add_result(KIND_LINE, line_buf[i], 5'd0);
    add_result(KIND_END, 7'd0, cur_len);
    if (cur_len != 5'd0) hist_len = cur_len;
    cur_len    = 5'd0;
    echoed_len = 5'd0;
  endfunction

  // predict one accepted input transaction; returns 0 when the byte is ignored
  function automatic bit advance_editor(in_item_t item);
    int unsigned queued_n;
    out_item_t   tail;
    logic [6:0]  c;
    queued_n = editor_output_q.size();
    if (item.operation == OP_RECEIVE) begin
      if (evt_pending || item.rx_byte[7]) return 1'b0;
      c = item.rx_byte[6:0];
      // arrow key escape prefix
      if (esc_step != 2'd0) begin
        esc_step = esc_step + 2'd1;
        if (esc_step == 2'd2) begin
          if (c == CHAR_BRACKET) return 1'b1;
          esc_step = 2'd0;
        end else begin
          if (c == CHAR_UP) post_event(EV_UP);
          else if (c == CHAR_DOWN) post_event(EV_DOWN);
          else if (c == CHAR_RIGHT || c == CHAR_LEFT) post_event(EV_NONE);
          esc_step = 2'd0;
          return 1'b1;
        end
      end
      // control bytes, then printable ones
      if (c < CHAR_SPACE) begin
        case (c)
          CHAR_ESC: esc_step = 2'd1;
          CHAR_BS:  post_event(EV_BACKSPACE);
          CHAR_TAB: post_event(EV_TAB);
          CHAR_CR:  post_event(EV_ENTER);
          default:  post_event(EV_NONE);
        endcase
      end else if (cur_len >= LINE_CAP) begin
        post_event(EV_OVERFLOW);
      end else begin
        line_buf[cur_len] = c;
        cur_len           = cur_len + 5'd1;
      end
      return 1'b1;
    end
    // service call: echo one character or handle the held event
    if (!evt_pending) begin
      if (echoed_len < cur_len) begin
        add_result(KIND_ECHO, line_buf[echoed_len], 5'd0);
        echoed_len = echoed_len + 5'd1;
      end
    end else begin
      case (evt_code)
        EV_BACKSPACE: begin
          if (cur_len != 5'd0) cur_len = cur_len - 5'd1;
          add_result(KIND_ECHO, CHAR_BS, 5'd0);
          add_result(KIND_ECHO, CHAR_SPACE, 5'd0);
          add_result(KIND_ECHO, CHAR_BS, 5'd0);
          echoed_len = cur_len;
        end
        EV_TAB: add_result(KIND_TAB, 7'd0, 5'd0);
        EV_ENTER: close_line();
        EV_UP: begin
          if (cur_len == 5'd0) begin
            // drop a trailing space of the history line
            if (hist_len != 5'd0 && line_buf[hist_len - 5'd1] == CHAR_SPACE)
              hist_len = hist_len - 5'd1;
            cur_len = hist_len;
            echo_whole_line();
          end
        end
        EV_DOWN: begin
          if (cur_len == 5'd0) begin
            cur_len = hist_len;
            echo_whole_line();
            close_line();
          end
        end
        EV_OVERFLOW: begin
          add_result(KIND_OVF, 7'd0, 5'd0);
          hist_len = cur_len;
          cur_len  = 5'd0;
        end
        default: ;
      endcase
      evt_pending = 1'b0;
    end
    // mark the final result of this transaction
    if (editor_output_q.size() > queued_n) begin
      tail      = editor_output_q.pop_back();
      tail.last = 1'b1;
      editor_output_q.push_back(tail);
    end
    return 1'b1;
  endfunction

  function automatic int unsigned pick_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 19);
  endfunction

  // offer one transaction and predict it once accepted
  task automatic send_item(input logic op, input logic [7:0] rx);
    int unsigned gap;
    in_item_t    item;
    gap = pick_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.operation = op;
    item.rx_byte   = rx;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    items_sent++;
    if (advance_editor(item)) items_acted++;
  endtask

  task automatic send_byte(input logic [7:0] rx);
    send_item(OP_RECEIVE, rx);
  endtask

  task automatic service_call();
    send_item(OP_SERVICE, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_escape(input logic [6:0] key);
    send_byte({1'b0, CHAR_ESC});
    send_byte({1'b0, CHAR_BRACKET});
    send_byte({1'b0, key});
  endtask

  // bytes above 127, bytes while an event is held, idle service
  task automatic test_ignored_input();
    send_byte(8'hFF);
    send_byte(8'h80);
    service_call();
    send_byte(8'h00);
    send_byte(8'h41);
    service_call();
  endtask

  // typing with DEL and a trailing space, then enter
  task automatic test_line_entry();
    send_byte(8'h71);
    send_byte(8'h7F);
    service_call();
    send_byte({1'b0, CHAR_SPACE});
    send_byte({1'b0, CHAR_CR});
    service_call();
  endtask

  // recall on an empty line, right key, down on a busy line
  task automatic test_arrow_keys();
    send_escape(CHAR_UP);
    service_call();
    send_escape(CHAR_RIGHT);
    service_call();
    send_escape(CHAR_DOWN);
    service_call();
  endtask

  // backspace, tab, broken prefixes, enter, then down on an empty line
  task automatic test_edit_keys();
    send_byte({1'b0, CHAR_BS});
    service_call();
    send_byte({1'b0, CHAR_TAB});
    service_call();
    send_byte({1'b0, CHAR_ESC});
    send_byte(8'h78);
    send_escape(7'h5A);
    send_byte({1'b0, CHAR_CR});
    service_call();
    send_escape(CHAR_DOWN);
    service_call();
  endtask

  // receiver holds off while the sender keeps pushing a long enter
  task automatic test_output_backpressure();
    no_idle         = 1'b1;
    hold_output_req = 1'b1;
    for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(33, 126)));
    send_byte({1'b0, CHAR_CR});
    service_call();
    repeat (6) service_call();
    no_idle = 1'b0;
  endtask

  // one line of random text with echoes, edits and noise mixed in
  task automatic type_line(input int unsigned n);
    logic [7:0]  ch;
    int unsigned r;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 5) == 0) ch = {1'b0, CHAR_SPACE};
      else ch = 8'($urandom_range(33, 127));
      send_byte(ch);
      r = $urandom_range(0, 15);
      if (r < 8) begin
        service_call();
      end else if (r == 8) begin
        send_byte({1'b0, CHAR_BS});
        service_call();
      end else if (r == 9) begin
        send_byte(8'($urandom_range(128, 255)));
      end
    end
    if ($urandom_range(0, 3) == 0) send_byte({1'b0, CHAR_SPACE});
    if ($urandom_range(0, 7) != 0) send_byte({1'b0, CHAR_CR});
    service_call();
  endtask

  // random editing sessions, mostly well-formed
  task automatic test_random_sessions(input int unsigned target);
    int unsigned pick;
    while (items_sent < target) begin
      no_idle = ($urandom_range(0, 4) == 0);
      pick    = $urandom_range(0, 11);
      if (pick <= 5) begin
        if ($urandom_range(0, 5) == 0) type_line($urandom_range(17, 22));
        else type_line($urandom_range(1, 12));
      end else if (pick <= 7) begin
        send_escape(CHAR_UP);
        service_call();
        if ($urandom_range(0, 1) == 0) begin
          send_byte({1'b0, CHAR_CR});
          service_call();
        end
      end else if (pick == 8) begin
        send_escape(CHAR_DOWN);
        service_call();
      end else if (pick == 9) begin
        case ($urandom_range(0, 3))
          0:       send_byte({1'b0, CHAR_TAB});
          1:       send_escape(CHAR_RIGHT);
          2:       send_escape(CHAR_LEFT);
          default: send_byte(8'($urandom_range(0, 31)));
        endcase
        service_call();
      end else if (pick == 10) begin
        send_byte({1'b0, CHAR_ESC});
        if ($urandom_range(0, 1) == 0) send_byte({1'b0, CHAR_BRACKET});
        send_byte(8'($urandom_range(0, 127)));
        service_call();
      end else begin
        repeat ($urandom_range(1, 4))
          send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end
    end
    no_idle = 1'b0;
  endtask

  // receiver: random stall per transaction, one long hold on request
  initial begin : receiver
    int unsigned n;
    forever begin
      if (hold_output_req) begin
        hold_output_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        n = pick_wait();
        if (n != 0) begin
          out_stall_i <= 1'b1;
          repeat (n) @(posedge clk_i);
        end
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o && !hold_output_req) @(posedge clk_i);
    end
  end

  // compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin : check_output
    out_item_t want;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (editor_output_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_CAP)
          $display("%0t: expected nothing, got kind=%0d char=%0d len=%0d last=%0d",
                   $time, out_data_o.kind, out_data_o.character,
                   out_data_o.line_length, out_data_o.last);
      end else begin
        want = editor_output_q.pop_front();
        results_checked++;
        if (out_data_o.kind !== want.kind || out_data_o.character !== want.character ||
            out_data_o.line_length !== want.line_length || out_data_o.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_CAP)
            $display("%0t: expected kind=%0d char=%0d len=%0d last=%0d, got %0d %0d %0d %0d",
                     $time, want.kind, want.character, want.line_length, want.last,
                     out_data_o.kind, out_data_o.character, out_data_o.line_length,
                     out_data_o.last);
        end
        if (want.kind == KIND_OVF) overflow_seen++;
        if (want.kind == KIND_END) lines_seen++;
        if (want.kind == KIND_TAB) tabs_seen++;
      end
    end
  end

  // watchdog on cycles without any transaction
  initial begin : watchdog
    do @(posedge clk_i); while (idle_cycles < IDLE_LIMIT);
    $display("%0t: no transaction for %0d cycles, %0d results outstanding",
             $time, IDLE_LIMIT, editor_output_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // test sequence
  initial begin : run
    no_idle         = 1'b0;
    hold_output_req = 1'b0;
    reset_editor_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_ignored_input();
    test_line_entry();
    test_arrow_keys();
    test_edit_keys();
    test_output_backpressure();
    test_random_sessions(items_sent + RANDOM_ITEMS);
    in_valid_i <= 1'b0;
    while (editor_output_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d input transactions (%0d acted on), %0d results checked",
             items_sent, items_acted, results_checked);
    $display("lines ended %0d, overflow notices %0d, tab requests %0d, one long output hold",
             lines_seen, overflow_seen, tabs_seen);
    if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire

[serial_line_editor.f]
rtl/sle_pkg.sv
rtl/sle_front.sv
rtl/sle_queue.sv
rtl/sle_back.sv
rtl/serial_line_editor.sv
bench/serial_line_editor_tb.sv
